// ----- rtl/core/tcc_pkg.sv -----
// Package for the text console cursor engine.
// Holds codes, the queued operation type and default sizes. Depends on nothing.
`default_nettype none
package tcc_pkg;

  localparam int DEF_GRID_COLUMNS = 64;
  localparam int DEF_GRID_ROWS    = 32;
  localparam int DEF_WINDOW_ROWS  = 8;
  localparam int DEF_WINDOW_TOP   = 24;
  localparam int DEF_PANEL_WIDTH  = 320;

  localparam logic [1:0] FN_PUT   = 2'd0;
  localparam logic [1:0] FN_SET   = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;
  localparam logic [1:0] FN_READ  = 2'd3;

  localparam logic [1:0] MODE_TEXT    = 2'd0;
  localparam logic [1:0] MODE_GFX     = 2'd1;
  localparam logic [1:0] MODE_SPLIT   = 2'd2;
  localparam logic [1:0] MODE_GFX_ALT = 2'd3;

  localparam logic REG_DISPLAY_MODE = 1'b0;
  localparam logic REG_SMALL_FONT   = 1'b1;

  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DEL   = 8'h7F;

  typedef enum logic [2:0] {
    OP_IGNORE,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_PRINT,
    OP_SET,
    OP_CLEAR,
    OP_READ
  } op_kind_t;

  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] ch;
    logic [7:0] col;
    logic [7:0] row;
  } op_t;

endpackage
`default_nettype wire

// ----- rtl/core/tcc_if.sv -----
// Handshake channels of the text console cursor engine.
// Input item channel and result channel, each with source and sink modports.
`default_nettype none
interface tcc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] char_code;
  logic [7:0] req_column;
  logic [7:0] req_row;
  modport source (output valid, func, char_code, req_column, req_row, input ready);
  modport sink (input valid, func, char_code, req_column, req_row, output ready);
endinterface

interface tcc_out_if;
  logic       valid;
  logic       ready;
  logic       scrolled;
  logic [5:0] cur_col;
  logic [4:0] cur_row;
  logic       panel_scroll;
  logic       draw_valid;
  logic [5:0] draw_col;
  logic [4:0] draw_row;
  logic [7:0] draw_char;
  logic       move_valid;
  logic [7:0] move_col;
  logic [7:0] move_row;
  logic [8:0] read_data;
  modport source (output valid, scrolled, cur_col, cur_row, panel_scroll, draw_valid,
                  draw_col, draw_row, draw_char, move_valid, move_col, move_row,
                  read_data, input ready);
  modport sink (input valid, scrolled, cur_col, cur_row, panel_scroll, draw_valid,
                draw_col, draw_row, draw_char, move_valid, move_col, move_row,
                read_data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/text_console_cursor_engine.sv -----
// Top level of the text console cursor engine: configuration registers,
// front end, operation queue and back end. Depends on tcc_pkg, tcc_if,
// tcc_front, tcc_queue and tcc_back.
//
// One result beat per input beat. Every operation but a read passes from the
// queue head through EXEC to the result register; a read passes through EXEC
// and READ, as the cell memory read is registered. A scroll then zeroes the
// row rotated in, sweeping every column, before the next operation is taken;
// a clear sweeps every row. After reset the same full sweep runs before the
// first beat is accepted; configuration writes are taken throughout.
`default_nettype none
module text_console_cursor_engine import tcc_pkg::*; #(
  parameter int GRID_COLUMNS = DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = DEF_GRID_ROWS,
  parameter int WINDOW_ROWS  = DEF_WINDOW_ROWS,
  parameter int WINDOW_TOP   = DEF_WINDOW_TOP,
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [1:0] cfg_wdata,
  tcc_in_if.sink          in_ch,
  tcc_out_if.source       out_ch
);

  logic [1:0] display_mode_r;
  logic       small_font_r;
  logic       q_full;
  logic       q_valid;
  logic       q_pop;
  logic       push;
  logic       init_busy;
  op_t        push_op;
  op_t        q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      display_mode_r <= MODE_TEXT;
      small_font_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DISPLAY_MODE: display_mode_r <= cfg_wdata;
        REG_SMALL_FONT:   small_font_r   <= cfg_wdata[0];
        default:          display_mode_r <= display_mode_r;
      endcase
    end
  end

  tcc_front u_front (
    .in_ch     (in_ch),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (push),
    .push_op   (push_op)
  );

  tcc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (q_pop),
    .full    (q_full),
    .valid   (q_valid),
    .head    (q_head)
  );

  tcc_back #(
    .GRID_COLUMNS (GRID_COLUMNS),
    .GRID_ROWS    (GRID_ROWS),
    .WINDOW_ROWS  (WINDOW_ROWS),
    .WINDOW_TOP   (WINDOW_TOP),
    .PANEL_WIDTH  (PANEL_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_op         (q_head),
    .q_pop        (q_pop),
    .display_mode (display_mode_r == MODE_GFX_ALT ? MODE_GFX : display_mode_r),
    .small_font   (small_font_r),
    .init_busy    (init_busy),
    .out_ch       (out_ch)
  );

`ifndef SYNTHESIS
  a_scroll_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.scrolled |-> out_ch.move_valid)
    else $error("scroll without cursor move");
  a_pscroll_scr: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.panel_scroll |-> out_ch.scrolled)
    else $error("panel scroll without scroll");
  a_read_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.draw_valid || out_ch.move_valid) |-> out_ch.read_data == 9'd0)
    else $error("read data with draw or move");
  a_no_accept_init: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !in_ch.ready)
    else $error("input accepted during clearing pass");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/tcc_front.sv -----
// Front end: takes input beats and classifies them into queued operations.
// Depends on tcc_pkg and tcc_in_if.
`default_nettype none
module tcc_front import tcc_pkg::*; (
  tcc_in_if.sink in_ch,
  input  wire logic q_full,
  input  wire logic init_busy,
  output logic      push,
  output op_t       push_op
);

  assign in_ch.ready = !q_full && !init_busy;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    push_op.ch  = in_ch.char_code;
    push_op.col = in_ch.req_column;
    push_op.row = in_ch.req_row;
    unique case (in_ch.func)
      FN_PUT: begin
        if (in_ch.char_code == CHAR_LF || in_ch.char_code == CHAR_CR) begin
          push_op.kind = OP_NEWLINE;
        end else if (in_ch.char_code == CHAR_BS) begin
          push_op.kind = OP_BACKSPACE;
        end else if (in_ch.char_code >= CHAR_SPACE && in_ch.char_code < CHAR_DEL) begin
          push_op.kind = OP_PRINT;
        end else begin
          push_op.kind = OP_IGNORE;
        end
      end
      FN_SET:   push_op.kind = OP_SET;
      FN_CLEAR: push_op.kind = OP_CLEAR;
      FN_READ:  push_op.kind = OP_READ;
      default:  push_op.kind = OP_IGNORE;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/tcc_queue.sv -----
// Two-entry operation queue between the front and back ends.
// Depends on tcc_pkg.
`default_nettype none
module tcc_queue import tcc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire op_t  push_op,
  input  wire logic pop,
  output logic      full,
  output logic      valid,
  output op_t       head
);

  op_t        ent_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign full  = cnt_r == 2'd2;
  assign valid = cnt_r != 2'd0;
  assign head  = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/tcc_back.sv -----
// Back end: executes queued operations on the character grid and cursor.
// Holds the cell memory with a rotating row base and the result register.
// Depends on tcc_pkg and tcc_out_if.
`default_nettype none
module tcc_back import tcc_pkg::*; #(
  parameter int GRID_COLUMNS = DEF_GRID_COLUMNS,
  parameter int GRID_ROWS    = DEF_GRID_ROWS,
  parameter int WINDOW_ROWS  = DEF_WINDOW_ROWS,
  parameter int WINDOW_TOP   = DEF_WINDOW_TOP,
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire op_t        q_op,
  output logic            q_pop,
  input  wire logic [1:0] display_mode,
  input  wire logic       small_font,
  output logic            init_busy,
  tcc_out_if.source       out_ch
);

  localparam int CW = $clog2(GRID_COLUMNS);
  localparam int RW = $clog2(GRID_ROWS);
  localparam int AW = CW + RW;
  localparam int FONT_S = (PANEL_WIDTH / 5 > GRID_COLUMNS) ? GRID_COLUMNS : PANEL_WIDTH / 5;
  localparam int FONT_B = (PANEL_WIDTH / 8 > GRID_COLUMNS) ? GRID_COLUMNS : PANEL_WIDTH / 8;
  localparam logic [7:0] GC8  = 8'(GRID_COLUMNS);
  localparam logic [7:0] GR8  = 8'(GRID_ROWS);
  localparam logic [7:0] WR8  = 8'(WINDOW_ROWS);
  localparam logic [7:0] WT8  = 8'(WINDOW_TOP);
  localparam logic [7:0] FS8  = 8'(FONT_S);
  localparam logic [7:0] FB8  = 8'(FONT_B);
  localparam logic [RW:0]   GR_W  = (RW + 1)'(GRID_ROWS);
  localparam logic [RW-1:0] GR_M1 = RW'(GRID_ROWS - 1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EXEC    = 3'd1;
  localparam logic [2:0] ST_READ    = 3'd2;
  localparam logic [2:0] ST_CLR_ROW = 3'd3;
  localparam logic [2:0] ST_CLR_ALL = 3'd4;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] line;
    logic [7:0] mc;
    logic [7:0] mr;
  } sc_t;

  typedef struct packed {
    logic       scr;
    logic       pscroll;
    logic       dv;
    logic [5:0] dc;
    logic [4:0] dr;
    logic [7:0] dch;
    logic       mv;
    logic [7:0] mc;
    logic [7:0] mr;
    logic [8:0] rd;
  } res_t;

  logic [7:0]     mem [1 << AW];
  logic [7:0]     rdata_r;
  logic [2:0]     state_r;
  logic           init_r;
  op_t            op_r;
  logic [CW-1:0]  cur_col_r;
  logic [RW-1:0]  cur_line_r;
  logic [RW-1:0]  ltr_r;
  logic [RW-1:0]  base_r;
  logic [GRID_ROWS-1:0] flags_r;
  logic [RW-1:0]  sw_row_r;
  logic [CW-1:0]  sw_col_r;
  logic           out_valid_r;
  res_t           res_r;
  logic [5:0]     out_col_r;
  logic [4:0]     out_row_r;

  logic           m0;
  logic           m2;
  logic [7:0]     font8;
  logic [7:0]     col;
  logic [7:0]     line;
  logic [7:0]     ltr;
  logic [7:0]     s;
  logic           bs_ok;
  sc_t            sc;
  res_t           r;
  logic           we;
  logic [7:0]     wcol;
  logic [7:0]     wline;
  logic [7:0]     wdata;
  logic           flag_we;
  logic           do_scroll;
  logic           do_clear;
  logic [GRID_ROWS-1:0] fl_nxt;
  logic           rd_ok;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic [RW-1:0]  base_nxt;

  function automatic logic [7:0] win_start(input logic [7:0] l);
    return (l >= WR8 - 8'd1) ? l - (WR8 - 8'd1) : 8'd0;
  endfunction

  function automatic logic in_win(input logic [7:0] l, input logic [7:0] st);
    return l >= st && l < st + WR8;
  endfunction

  function automatic logic [7:0] win_row(input logic [7:0] l, input logic [7:0] st);
    return WT8 + l - st;
  endfunction

  function automatic sc_t set_cur(input logic [7:0] c, input logic [7:0] rr,
                                  input logic [7:0] lt, input logic split,
                                  input logic [7:0] fnt);
    sc_t        o;
    logic [7:0] maxc;
    logic [7:0] st;
    maxc   = fnt - 8'd1;
    st     = win_start(lt);
    o.col  = (c < maxc) ? c : maxc;
    o.line = (rr < GR8) ? rr : GR8 - 8'd1;
    if (!split) begin
      o.mc = o.col;
      o.mr = o.line;
    end else if (in_win(o.line, st)) begin
      o.mc = o.col;
      o.mr = win_row(o.line, st);
    end else begin
      o.mc = c;
      o.mr = rr;
    end
    return o;
  endfunction

  function automatic logic [RW-1:0] phys(input logic [RW-1:0] l, input logic [RW-1:0] b);
    logic [RW:0] sum;
    sum = {1'b0, l} + {1'b0, b};
    if (sum >= GR_W) begin
      sum = sum - GR_W;
    end
    return sum[RW-1:0];
  endfunction

  assign m0    = display_mode == MODE_TEXT;
  assign m2    = display_mode == MODE_SPLIT;
  assign font8 = small_font ? FS8 : FB8;
  assign rd_ok = op_r.row < GR8 && op_r.col < GC8;

  always_comb begin
    col       = 8'(cur_col_r);
    line      = 8'(cur_line_r);
    ltr       = 8'(ltr_r);
    s         = win_start(8'(ltr_r));
    bs_ok     = 1'b0;
    sc        = '0;
    r         = '0;
    we        = 1'b0;
    wcol      = col;
    wline     = line;
    wdata     = 8'd0;
    flag_we   = 1'b0;
    do_scroll = 1'b0;
    do_clear  = 1'b0;
    unique case (op_r.kind)
      OP_NEWLINE: begin
        flag_we = 1'b1;
        col     = 8'd0;
        line    = line + 8'd1;
        if (!m2) begin
          if (line >= GR8) begin
            do_scroll = 1'b1;
            r.pscroll = m0;
            r.scr     = 1'b1;
            sc        = set_cur(8'd0, GR8 - 8'd1, ltr, 1'b0, font8);
            col       = sc.col;
            line      = sc.line;
            r.mv      = 1'b1;
            r.mc      = sc.mc;
            r.mr      = sc.mr;
          end
        end else begin
          if (line >= s + WR8) begin
            if (ltr == GR8 - 8'd1) begin
              do_scroll = 1'b1;
            end else begin
              ltr = ltr + 8'd1;
              s   = s + 8'd1;
            end
            r.pscroll = 1'b1;
            r.scr     = 1'b1;
            sc        = set_cur(8'd0, s + WR8 - 8'd1, ltr, 1'b1, font8);
            col       = sc.col;
            line      = sc.line;
            r.mv      = 1'b1;
            r.mc      = sc.mc;
            r.mr      = sc.mr;
          end else if (line >= GR8) begin
            line = GR8 - 8'd1;
          end
        end
        ltr = line;
      end
      OP_BACKSPACE: begin
        if (col != 8'd0) begin
          col   = col - 8'd1;
          bs_ok = 1'b1;
        end else if (line != 8'd0) begin
          line  = line - 8'd1;
          col   = font8 - 8'd1;
          bs_ok = 1'b1;
        end
        if (bs_ok) begin
          we    = 1'b1;
          wcol  = col;
          wline = line;
          if (m0) begin
            r.dv  = 1'b1;
            r.dc  = 6'(col);
            r.dr  = 5'(line);
            r.dch = CHAR_SPACE;
            sc    = set_cur(col, line, ltr, 1'b0, font8);
            col   = sc.col;
            line  = sc.line;
            r.mv  = 1'b1;
            r.mc  = sc.mc;
            r.mr  = sc.mr;
          end else if (m2 && in_win(line, s)) begin
            r.dv  = 1'b1;
            r.dc  = 6'(col);
            r.dr  = 5'(win_row(line, s));
            r.dch = CHAR_SPACE;
            r.mv  = 1'b1;
            r.mc  = col;
            r.mr  = win_row(line, s);
          end
        end
      end
      OP_PRINT: begin
        we    = 1'b1;
        wdata = op_r.ch;
        if (m0) begin
          r.dv  = 1'b1;
          r.dc  = 6'(col);
          r.dr  = 5'(line);
          r.dch = op_r.ch;
          r.mv  = 1'b1;
          r.mc  = col + 8'd1;
          r.mr  = line;
        end else if (m2 && in_win(line, s)) begin
          r.dv  = 1'b1;
          r.dc  = 6'(col);
          r.dr  = 5'(win_row(line, s));
          r.dch = op_r.ch;
          r.mv  = 1'b1;
          r.mc  = col + 8'd1;
          r.mr  = win_row(line, s);
        end
        col = col + 8'd1;
        if (col >= GC8) begin
          col  = 8'd0;
          line = line + 8'd1;
          if (line >= GR8) begin
            do_scroll = 1'b1;
            line      = GR8 - 8'd1;
            r.scr     = 1'b1;
            r.mv      = 1'b1;
            r.mc      = 8'd0;
            r.mr      = line;
          end
        end
      end
      OP_SET: begin
        sc   = set_cur(op_r.col, op_r.row, ltr, m2, font8);
        col  = sc.col;
        line = sc.line;
        r.mv = 1'b1;
        r.mc = sc.mc;
        r.mr = sc.mr;
      end
      OP_CLEAR: begin
        ltr      = 8'd0;
        do_clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    fl_nxt = flags_r;
    if (flag_we) begin
      fl_nxt[cur_line_r] = small_font;
    end
    if (do_scroll) begin
      fl_nxt = {small_font, fl_nxt[GRID_ROWS-1:1]};
    end
  end

  assign base_nxt = (base_r == GR_M1) ? '0 : base_r + RW'(1);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {sw_row_r, sw_col_r};
    mem_wdata = 8'd0;
    if (state_r == ST_EXEC && we) begin
      mem_we    = 1'b1;
      mem_waddr = {phys(wline[RW-1:0], base_r), wcol[CW-1:0]};
      mem_wdata = wdata;
    end else if (state_r == ST_CLR_ROW || state_r == ST_CLR_ALL) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state_r == ST_EXEC && op_r.kind == OP_READ) begin
      rdata_r <= mem[{phys(op_r.row[RW-1:0], base_r), op_r.col[CW-1:0]}];
    end
  end

  assign q_pop     = state_r == ST_IDLE && q_valid && (!out_valid_r || out_ch.ready);
  assign init_busy = init_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_r <= q_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR_ALL;
      init_r      <= 1'b1;
      cur_col_r   <= '0;
      cur_line_r  <= '0;
      ltr_r       <= '0;
      base_r      <= '0;
      flags_r     <= '0;
      sw_row_r    <= '0;
      sw_col_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            state_r <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (op_r.kind == OP_READ) begin
            state_r <= ST_READ;
          end else begin
            cur_col_r   <= col[CW-1:0];
            cur_line_r  <= line[RW-1:0];
            ltr_r       <= ltr[RW-1:0];
            flags_r     <= fl_nxt;
            out_valid_r <= 1'b1;
            res_r       <= r;
            out_col_r   <= 6'(col[CW-1:0]);
            out_row_r   <= 5'(line[RW-1:0]);
            sw_col_r    <= '0;
            if (do_scroll) begin
              sw_row_r <= base_r;
              base_r   <= base_nxt;
              state_r  <= ST_CLR_ROW;
            end else if (do_clear) begin
              sw_row_r <= '0;
              state_r  <= ST_CLR_ALL;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_READ: begin
          out_valid_r <= 1'b1;
          res_r       <= '{rd: (rd_ok ? {flags_r[op_r.row[RW-1:0]], rdata_r} : 9'd0),
                           default: '0};
          out_col_r   <= 6'(cur_col_r);
          out_row_r   <= 5'(cur_line_r);
          state_r     <= ST_IDLE;
        end
        ST_CLR_ROW: begin
          sw_col_r <= sw_col_r + CW'(1);
          if (&sw_col_r) begin
            state_r <= ST_IDLE;
          end
        end
        ST_CLR_ALL: begin
          sw_col_r <= sw_col_r + CW'(1);
          if (&sw_col_r) begin
            if (sw_row_r == GR_M1) begin
              init_r  <= 1'b0;
              state_r <= ST_IDLE;
            end else begin
              sw_row_r <= sw_row_r + RW'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.scrolled     = res_r.scr;
  assign out_ch.cur_col      = out_col_r;
  assign out_ch.cur_row      = out_row_r;
  assign out_ch.panel_scroll = res_r.pscroll;
  assign out_ch.draw_valid   = res_r.dv;
  assign out_ch.draw_col     = res_r.dc;
  assign out_ch.draw_row     = res_r.dr;
  assign out_ch.draw_char    = res_r.dch;
  assign out_ch.move_valid   = res_r.mv;
  assign out_ch.move_col     = res_r.mc;
  assign out_ch.move_row     = res_r.mr;
  assign out_ch.read_data    = res_r.rd;

endmodule
`default_nettype wire
